// ===== rtl/fss_pkg.sv =====
// Shared types, operation codes, limits and case folding for the fuzzy subsequence scorer.
package fss_pkg;

   localparam int PATTERN_DEPTH_DEFAULT = 64;
   localparam int RunWidth = 7;
   localparam int ScoreWidth = 14;
   localparam int GainWidth = 10;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEXT = 2'd2;
   localparam logic [1:0] OP_EOL = 2'd3;

   localparam logic [RunWidth-1:0] RUN_MAX = 7'd127;
   localparam logic [ScoreWidth-1:0] SCORE_MAX = 14'd16383;
   localparam logic [ScoreWidth-1:0] EMPTY_SCORE = 14'd1;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [ScoreWidth-1:0] score;
      logic                  matched;
   } rsp_type;

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b inside {[8'h41:8'h5A]}) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== rtl/fss_match.sv =====
// Pattern memory with read-ahead of the next pattern byte, match state and line scoring.
module fss_match #(
   parameter int PATTERN_DEPTH = fss_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  fss_pkg::req_type item,
   output logic             push,
   output fss_pkg::rsp_type result
);

   localparam int LW = $clog2(PATTERN_DEPTH + 1);
   localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

   logic [7:0] store_mem [PATTERN_DEPTH];
   logic [7:0] want_ff;

   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [fss_pkg::RunWidth-1:0] run_ff, run_in;
   logic [fss_pkg::ScoreWidth-1:0] score_ff, score_in;

   logic          wr_en;
   logic [7:0]    wr_byte;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          hit;
   logic [fss_pkg::GainWidth-1:0] gain;
   logic [fss_pkg::ScoreWidth:0]  sum;

   assign wr_byte = fss_pkg::fold_case(item.data_byte);
   assign wr_addr = len_ff[AW-1:0];
   assign rd_addr = pos_in[AW-1:0];
   assign hit = (want_ff == wr_byte);
   assign gain = {1'b0, run_ff, 2'b00} + {3'b000, run_ff} + fss_pkg::GainWidth'(1);
   assign sum = {1'b0, score_ff} + {5'b00000, gain};

   always_comb begin
      len_in = len_ff;
      pos_in = pos_ff;
      run_in = run_ff;
      score_in = score_ff;
      wr_en = 1'b0;
      push = 1'b0;
      result = '0;
      if (accept) begin
         case (item.operation)
            fss_pkg::OP_CLEAR: begin
               len_in = '0;
               pos_in = '0;
               run_in = '0;
               score_in = '0;
            end
            fss_pkg::OP_APPEND: begin
               if (len_ff < LW'(PATTERN_DEPTH)) begin
                  wr_en = 1'b1;
                  len_in = len_ff + LW'(1);
               end
               pos_in = '0;
               run_in = '0;
               score_in = '0;
            end
            fss_pkg::OP_TEXT: begin
               if (pos_ff < len_ff) begin
                  if (hit) begin
                     pos_in = pos_ff + LW'(1);
                     if (run_ff != fss_pkg::RUN_MAX) begin
                        run_in = run_ff + fss_pkg::RunWidth'(1);
                     end
                     if (sum > {1'b0, fss_pkg::SCORE_MAX}) begin
                        score_in = fss_pkg::SCORE_MAX;
                     end else begin
                        score_in = sum[fss_pkg::ScoreWidth-1:0];
                     end
                  end else begin
                     run_in = '0;
                  end
               end
            end
            fss_pkg::OP_EOL: begin
               push = 1'b1;
               if (len_ff == '0) begin
                  result.score = fss_pkg::EMPTY_SCORE;
               end else if (pos_ff == len_ff) begin
                  result.score = score_ff;
               end else begin
                  result.score = '0;
               end
               result.matched = (result.score != '0);
               pos_in = '0;
               run_in = '0;
               score_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // read ahead the byte at the next match position; forward a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_byte;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         want_ff <= wr_byte;
      end else begin
         want_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         pos_ff <= '0;
         run_ff <= '0;
         score_ff <= '0;
      end else begin
         len_ff <= len_in;
         pos_ff <= pos_in;
         run_ff <= run_in;
         score_ff <= score_in;
      end
   end

endmodule

// ===== rtl/fss_out_queue.sv =====
// Two-entry result queue: output register plus skid stage.
module fss_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fss_pkg::rsp_type push_item,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fss_pkg::rsp_type rsp_item
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   fss_pkg::rsp_type out_item_ff, out_item_in;
   fss_pkg::rsp_type skid_item_ff, skid_item_in;
   logic             pop;

   assign pop = out_valid_ff && rsp_ready;
   assign full = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item = out_item_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in = out_item_ff;
      skid_item_in = skid_item_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_item_in = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_item_in = push_item;
            out_valid_in = 1'b1;
         end else begin
            skid_item_in = push_item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

// ===== rtl/fuzzy_subsequence_scorer_top.sv =====
// Top level of the fuzzy subsequence scorer.
// Scores text lines against a stored pattern of up to PATTERN_DEPTH bytes, case-insensitive
// for A-Z. Items (clear, append, text byte, end of line) are taken one item per cycle while
// the result queue is not full: the pattern memory is read ahead at the next match position,
// so each text byte needs one compare and one saturating add. An end-of-line result goes to
// the output register, or the skid stage if it is occupied; with a two-entry result queue
// the input stalls only while two results wait unread. No clearing pass after reset.
module fuzzy_subsequence_scorer_top #(
   parameter int PATTERN_DEPTH = fss_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fss_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fss_pkg::rsp_type rsp_item
);

   logic             accept;
   logic             push;
   logic             full;
   fss_pkg::rsp_type result;

   assign req_ready = !full;
   assign accept = req_valid && req_ready;

   fss_match #(
      .PATTERN_DEPTH(PATTERN_DEPTH)
   ) u_match (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_item),
      .push   (push),
      .result (result)
   );

   fss_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== rtl/fss_checker.sv =====
// Port-level checks for the fuzzy subsequence scorer, bound to the top level.
module fss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input fss_pkg::req_type req_item,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fss_pkg::rsp_type rsp_item
);

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   a_matched_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.matched == (rsp_item.score != '0))
      else $error("matched flag disagrees with score");

   a_eol_result: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_item.operation == fss_pkg::OP_EOL && !rsp_valid |=> rsp_valid)
      else $error("end of line gave no result item");

   a_empty_pattern: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_item.operation == fss_pkg::OP_CLEAR) ##1
      (req_acc && req_item.operation == fss_pkg::OP_EOL && !rsp_valid)
      |=> rsp_valid && rsp_item.score == fss_pkg::EMPTY_SCORE)
      else $error("empty pattern did not score one");

endmodule

bind fuzzy_subsequence_scorer_top fss_checker u_fss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// ===== dv/fuzzy_subsequence_scorer_checker.sv =====
// Checker for the fuzzy subsequence scorer: predicts line scores from accepted items and compares.
module fuzzy_subsequence_scorer_checker #(
   parameter int DEPTH = fss_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  fss_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  fss_pkg::rsp_type rsp_item,
   output int unsigned      mismatch_count,
   output int unsigned      scores_pending
);

   localparam int RUN_BONUS = 5;

   logic [7:0]                      pattern_bytes [DEPTH];
   int unsigned                     pattern_len;
   int unsigned                     match_pos;
   logic [fss_pkg::RunWidth-1:0]    hit_run;
   logic [fss_pkg::ScoreWidth-1:0]  line_score;
   fss_pkg::rsp_type                expected_scores [$];
   fss_pkg::rsp_type                oldest;

   function automatic logic [7:0] lower_ascii(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic drop_line_progress();
      match_pos = 0;
      hit_run = '0;
      line_score = '0;
   endtask

   task automatic apply_item(input fss_pkg::req_type it);
      int unsigned      sum;
      fss_pkg::rsp_type res;
      case (it.operation)
         fss_pkg::OP_CLEAR: begin
            pattern_len = 0;
            drop_line_progress();
         end
         fss_pkg::OP_APPEND: begin
            if (pattern_len < DEPTH) begin
               pattern_bytes[pattern_len] = it.data_byte;
               pattern_len++;
            end
            drop_line_progress();
         end
         fss_pkg::OP_TEXT: begin
            if (match_pos < pattern_len) begin
               if (lower_ascii(pattern_bytes[match_pos]) == lower_ascii(it.data_byte)) begin
                  sum = line_score + 1 + RUN_BONUS * hit_run;
                  line_score = (sum > fss_pkg::SCORE_MAX) ? fss_pkg::SCORE_MAX :
                                                             sum[fss_pkg::ScoreWidth-1:0];
                  if (hit_run != fss_pkg::RUN_MAX) begin
                     hit_run++;
                  end
                  match_pos++;
               end else begin
                  hit_run = '0;
               end
            end
         end
         default: begin
            if (pattern_len == 0) begin
               res.score = fss_pkg::EMPTY_SCORE;
            end else if (match_pos == pattern_len) begin
               res.score = line_score;
            end else begin
               res.score = '0;
            end
            res.matched = (res.score != 0);
            expected_scores.push_back(res);
            drop_line_progress();
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_len = 0;
         drop_line_progress();
         expected_scores.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scores.size() == 0) begin
               flag_mismatch($sformatf("unexpected result, score %0d matched %0b",
                                       rsp_item.score, rsp_item.matched));
            end else begin
               oldest = expected_scores.pop_front();
               if (rsp_item.score !== oldest.score) begin
                  flag_mismatch($sformatf("score %0d, predicted %0d",
                                          rsp_item.score, oldest.score));
               end
               if (rsp_item.matched !== oldest.matched) begin
                  flag_mismatch($sformatf("matched %0b, predicted %0b",
                                          rsp_item.matched, oldest.matched));
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_item(req_item);
         end
      end
      scores_pending = expected_scores.size();
   end

endmodule

// ===== dv/tb_fuzzy_subsequence_scorer_top.sv =====
// Testbench top for the fuzzy subsequence scorer: item stimulus, result back-pressure, verdict.
module tb_fuzzy_subsequence_scorer_top;

   localparam int PATTERN_DEPTH = fss_pkg::PATTERN_DEPTH_DEFAULT;
   localparam int ITEM_TARGET = 1700;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   fss_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   fss_pkg::rsp_type rsp_item;
   int unsigned      mismatch_count;
   int unsigned      scores_pending;
   int unsigned      cycle_count = 0;
   int unsigned      items_sent = 0;
   int unsigned      burst_left = 0;
   bit               hold_request = 1'b0;
   logic [7:0]       pattern_copy [$];

   always #5 clock = ~clock;

   fuzzy_subsequence_scorer_top #(
      .PATTERN_DEPTH(PATTERN_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   fuzzy_subsequence_scorer_checker #(
      .DEPTH(PATTERN_DEPTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item),
      .mismatch_count(mismatch_count),
      .scores_pending(scores_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_fuzzy_subsequence_scorer_top NOT OK");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] b);
      fss_pkg::req_type it;
      bit               taken;
      it.operation = op;
      it.data_byte = b;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) :
                                                     $urandom_range(1, 20);
      end
      req_item <= it;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      burst_left--;
      items_sent++;
   endtask

   function automatic logic [7:0] pick_pattern_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'h61 + 8'($urandom_range(0, 25));
      if (r < 70) return 8'h41 + 8'($urandom_range(0, 25));
      if (r < 80) return 8'h30 + 8'($urandom_range(0, 9));
      if (r < 90) begin
         case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h40;
            2: return 8'h5B;
            3: return 8'h60;
            4: return 8'h7B;
            default: return 8'hFF;
         endcase
      end
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] text_form(input logic [7:0] b);
      logic [7:0] low;
      low = b | 8'h20;
      if (low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 1) == 1) return b ^ 8'h20;
      return b;
   endfunction

   task automatic append_byte(input logic [7:0] b);
      send_item(fss_pkg::OP_APPEND, b);
      if (pattern_copy.size() < PATTERN_DEPTH) begin
         pattern_copy.push_back(b);
      end
   endtask

   task automatic send_noise_text(input int unsigned count);
      repeat (count) send_item(fss_pkg::OP_TEXT, 8'($urandom));
   endtask

   task automatic send_line();
      int unsigned n;
      int unsigned r;
      n = pattern_copy.size();
      if ($urandom_range(0, 9) == 0) begin
         send_noise_text($urandom_range(0, 12));
      end else begin
         for (int i = 0; i < n; i++) begin
            send_noise_text(($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3));
            r = $urandom_range(0, 99);
            if (r < 3) begin
               append_byte(pick_pattern_byte());
            end else if (r < 5) begin
               send_item(fss_pkg::OP_CLEAR, 8'($urandom));
               pattern_copy.delete();
               break;
            end else if (r < 11) begin
               continue;
            end
            send_item(fss_pkg::OP_TEXT, text_form(pattern_copy[i]));
         end
         send_noise_text($urandom_range(0, 3));
      end
      send_item(fss_pkg::OP_EOL, 8'($urandom));
   endtask

   initial begin
      stall_mode_type mode;
      int unsigned    seg;
      bit             hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode = stall_mode_type'($urandom_range(0, 3));
            seg = $urandom_range(10, 80);
            for (int k = 0; k < seg; k++) begin
               case (mode)
                  STALL_NONE:  rsp_ready <= 1'b1;
                  STALL_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
                  STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default:     rsp_ready <= ((k % 5) < 2);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int unsigned r;
      int unsigned len;
      logic [1:0]  op;
      logic [7:0]  b;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(fss_pkg::OP_EOL, 8'hFF);
      send_item(fss_pkg::OP_TEXT, 8'hFF);
      send_item(fss_pkg::OP_EOL, 8'h00);
      send_item(fss_pkg::OP_APPEND, 8'h41);
      send_item(fss_pkg::OP_APPEND, 8'h00);
      send_item(fss_pkg::OP_TEXT, 8'h61);
      send_item(fss_pkg::OP_TEXT, 8'h00);
      send_item(fss_pkg::OP_TEXT, 8'h78);
      send_item(fss_pkg::OP_EOL, 8'h55);
      send_item(fss_pkg::OP_TEXT, 8'h61);
      send_item(fss_pkg::OP_APPEND, 8'h7B);
      send_item(fss_pkg::OP_TEXT, 8'h41);
      send_item(fss_pkg::OP_TEXT, 8'h01);
      send_item(fss_pkg::OP_TEXT, 8'h00);
      send_item(fss_pkg::OP_TEXT, 8'h5B);
      send_item(fss_pkg::OP_TEXT, 8'h7B);
      send_item(fss_pkg::OP_EOL, 8'hAA);
      send_item(fss_pkg::OP_TEXT, 8'h61);
      send_item(fss_pkg::OP_EOL, 8'h00);
      send_item(fss_pkg::OP_CLEAR, 8'hFF);
      send_item(fss_pkg::OP_EOL, 8'h00);
      send_item(fss_pkg::OP_APPEND, 8'hFF);
      send_item(fss_pkg::OP_TEXT, 8'hFF);
      send_item(fss_pkg::OP_EOL, 8'hFF);
      pattern_copy.delete();
      pattern_copy.push_back(8'hFF);

      for (int set_idx = 0; items_sent < ITEM_TARGET; set_idx++) begin
         if (items_sent >= 500) begin
            hold_request = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 6 && set_idx > 0) begin
            repeat ($urandom_range(1, 6)) begin
               op = 2'($urandom_range(0, 3));
               b = 8'($urandom);
               send_item(op, b);
               if (op == fss_pkg::OP_CLEAR) begin
                  pattern_copy.delete();
               end else if (op == fss_pkg::OP_APPEND && pattern_copy.size() < PATTERN_DEPTH) begin
                  pattern_copy.push_back(b);
               end
            end
         end else begin
            if (set_idx == 0 || $urandom_range(0, 3) != 0) begin
               send_item(fss_pkg::OP_CLEAR, 8'($urandom));
               pattern_copy.delete();
            end
            r = $urandom_range(0, 99);
            if (set_idx == 0) len = PATTERN_DEPTH + 6;
            else if (r < 5) len = 0;
            else if (r < 75) len = $urandom_range(1, 8);
            else if (r < 95) len = $urandom_range(9, 30);
            else len = $urandom_range(PATTERN_DEPTH - 4, PATTERN_DEPTH + 6);
            repeat (len) append_byte(pick_pattern_byte());
            repeat ($urandom_range(1, 4)) send_line();
         end
      end

      req_valid <= 1'b0;
      while (scores_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && scores_pending == 0) begin
         $display("tb_fuzzy_subsequence_scorer_top OK");
      end else begin
         $display("tb_fuzzy_subsequence_scorer_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== fuzzy_subsequence_scorer_top.f =====
rtl/fss_pkg.sv
rtl/fss_match.sv
rtl/fss_out_queue.sv
rtl/fuzzy_subsequence_scorer_top.sv
rtl/fss_checker.sv
dv/fuzzy_subsequence_scorer_checker.sv
dv/tb_fuzzy_subsequence_scorer_top.sv
